FILE: hdl/nlc_pkg.sv
// shared types and constants for the numeric literal classifier
package nlc_pkg;

    // character codes used by the scanner
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_DOT     = 8'h2E;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_UP_A    = 8'h41;
    localparam logic [7:0] CHAR_UP_F    = 8'h46;
    localparam logic [7:0] CHAR_UP_X    = 8'h58;
    localparam logic [7:0] CHAR_LOW_A   = 8'h61;
    localparam logic [7:0] CHAR_LOW_F   = 8'h66;
    localparam logic [7:0] CHAR_LOW_X   = 8'h78;

    // saturation limit of the position and dot counters
    localparam logic [1:0] COUNT_LIMIT  = 2'd3;

    // class codes
    typedef enum logic [2:0] {
        CLASS_HEX     = 3'd0,
        CLASS_INTEGER = 3'd1,
        CLASS_FLOAT   = 3'd2,
        CLASS_UNKNOWN = 3'd3,
        CLASS_ERROR   = 3'd4
    } t_class;

    // per-token scan state
    typedef struct packed {
        logic [1:0] char_position;
        logic [1:0] dots_seen;
        logic       integer_pass;
        logic       float_pass;
        logic       hex_pass;
    } t_scan_state;

    localparam t_scan_state SCAN_RESET = '{
        char_position: 2'd0,
        dots_seen:     2'd0,
        integer_pass:  1'b1,
        float_pass:    1'b1,
        hex_pass:      1'b1
    };

endpackage

FILE: hdl/nlc_scan.sv
// next-state and class logic for one character of a token
module nlc_scan (
    input  nlc_pkg::t_scan_state i_state,
    input  logic [7:0]           i_char_code,
    output nlc_pkg::t_scan_state o_state,
    output nlc_pkg::t_class      o_number_class
);

    logic is_dec;
    logic is_hex;
    logic is_dot;
    logic sign_ok;
    logic hex_ok;

    // character classes
    always_comb begin
        is_dec  = (i_char_code >= nlc_pkg::CHAR_ZERO) && (i_char_code <= nlc_pkg::CHAR_NINE);
        is_hex  = is_dec
                || ((i_char_code >= nlc_pkg::CHAR_LOW_A) && (i_char_code <= nlc_pkg::CHAR_LOW_F))
                || ((i_char_code >= nlc_pkg::CHAR_UP_A) && (i_char_code <= nlc_pkg::CHAR_UP_F));
        is_dot  = (i_char_code == nlc_pkg::CHAR_DOT);
        sign_ok = (i_state.char_position == 2'd0) && (i_char_code == nlc_pkg::CHAR_MINUS);
    end

    // hex prefix check depends on position
    always_comb begin
        case (i_state.char_position)
            2'd0:    hex_ok = (i_char_code == nlc_pkg::CHAR_ZERO);
            2'd1:    hex_ok = (i_char_code == nlc_pkg::CHAR_LOW_X)
                           || (i_char_code == nlc_pkg::CHAR_UP_X);
            default: hex_ok = is_hex;
        endcase
    end

    // state update with saturating counters
    always_comb begin
        o_state = i_state;
        if (is_dot && (i_state.dots_seen < nlc_pkg::COUNT_LIMIT)) begin
            o_state.dots_seen = i_state.dots_seen + 2'd1;
        end
        if (i_state.char_position < nlc_pkg::COUNT_LIMIT) begin
            o_state.char_position = i_state.char_position + 2'd1;
        end
        o_state.integer_pass = i_state.integer_pass & (is_dec | sign_ok);
        o_state.float_pass   = i_state.float_pass & (is_dec | is_dot | sign_ok);
        o_state.hex_pass     = i_state.hex_pass & hex_ok;
    end

    // class in priority order, error first
    always_comb begin
        if (o_state.dots_seen >= 2'd2) begin
            o_number_class = nlc_pkg::CLASS_ERROR;
        end else if (o_state.hex_pass && (i_state.char_position >= 2'd2)) begin
            o_number_class = nlc_pkg::CLASS_HEX;
        end else if (o_state.integer_pass) begin
            o_number_class = nlc_pkg::CLASS_INTEGER;
        end else if (o_state.float_pass && (o_state.dots_seen == 2'd1)) begin
            o_number_class = nlc_pkg::CLASS_FLOAT;
        end else begin
            o_number_class = nlc_pkg::CLASS_UNKNOWN;
        end
    end

endmodule

FILE: hdl/number_literal_classifier_core.sv
// top level of the numeric literal classifier: scan state and result register
//
//  channel   valid     stall     payload
//  input     i_valid   o_stall   i_char_code, i_last_char
//  output    o_valid   i_stall   o_number_class
//
// one character per cycle while o_stall is low; the class of a token appears
// in the cycle after the transfer of its last character, from the result register.
// synchronous active-low reset returns the scan state to its token start.
// characters that are not last are taken even while a result waits;
// a last character is held off only while the result register is full and stalled.
module number_literal_classifier_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_char_code,
    input  logic       i_last_char,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_number_class
);

    nlc_pkg::t_scan_state r_state;
    nlc_pkg::t_scan_state n_state;
    nlc_pkg::t_class      n_class;
    nlc_pkg::t_class      r_class;
    logic                 r_out_valid;
    logic                 in_xfer;
    logic                 out_xfer;

    nlc_scan u_scan (
        .i_state        (r_state),
        .i_char_code    (i_char_code),
        .o_state        (n_state),
        .o_number_class (n_class)
    );

    // handshake
    assign o_stall  = r_out_valid & i_stall & i_last_char;
    assign in_xfer  = i_valid & ~o_stall;
    assign out_xfer = r_out_valid & ~i_stall;

    // scan state, back to token start after the last character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nlc_pkg::SCAN_RESET;
        end else if (in_xfer) begin
            r_state <= i_last_char ? nlc_pkg::SCAN_RESET : n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer && i_last_char) begin
            r_out_valid <= 1'b1;
        end else if (out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && i_last_char) begin
            r_class <= n_class;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_number_class = r_class;

`ifndef SYNTHESIS
    // a new result appears only after a last-character transfer
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(in_xfer && i_last_char))
        else $error("result without a last character");

    // token end returns the scan state to its start
    a_state_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_last_char) |=> (r_state == nlc_pkg::SCAN_RESET))
        else $error("scan state not cleared after token end");

    // an unaccepted pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |-> !(in_xfer && i_last_char))
        else $error("pending result overwritten");
`endif

endmodule
